// ===== src/bknc_pkg.sv =====
// Package for the block keyword nesting checker.
// Holds statement kind codes, status codes, the stack entry layout and the rule table.
// No dependencies.
`default_nettype none

package bknc_pkg;

    localparam int KIND_W = 5;
    localparam int LINE_W = 16;
    localparam int STATUS_W = 3;
    localparam int STACK_DEPTH_DEF = 64;

    localparam logic [KIND_W-1:0] K_NONE      = 5'd0;
    localparam logic [KIND_W-1:0] K_FOR       = 5'd1;
    localparam logic [KIND_W-1:0] K_IF        = 5'd2;
    localparam logic [KIND_W-1:0] K_ELIF      = 5'd3;
    localparam logic [KIND_W-1:0] K_ELSE      = 5'd4;
    localparam logic [KIND_W-1:0] K_WHILE     = 5'd5;
    localparam logic [KIND_W-1:0] K_REPEAT    = 5'd6;
    localparam logic [KIND_W-1:0] K_LOOP      = 5'd7;
    localparam logic [KIND_W-1:0] K_CASE      = 5'd8;
    localparam logic [KIND_W-1:0] K_WHEN      = 5'd9;
    localparam logic [KIND_W-1:0] K_OTHERWISE = 5'd10;
    localparam logic [KIND_W-1:0] K_TRAP      = 5'd11;
    localparam logic [KIND_W-1:0] K_HANDLER   = 5'd12;
    localparam logic [KIND_W-1:0] K_PROC      = 5'd13;
    localparam logic [KIND_W-1:0] K_FUNC      = 5'd14;
    localparam logic [KIND_W-1:0] K_ENDFOR    = 5'd15;
    localparam logic [KIND_W-1:0] K_ENDIF     = 5'd16;
    localparam logic [KIND_W-1:0] K_ENDWHILE  = 5'd17;
    localparam logic [KIND_W-1:0] K_UNTIL     = 5'd18;
    localparam logic [KIND_W-1:0] K_ENDLOOP   = 5'd19;
    localparam logic [KIND_W-1:0] K_ENDCASE   = 5'd20;
    localparam logic [KIND_W-1:0] K_ENDTRAP   = 5'd21;
    localparam logic [KIND_W-1:0] K_ENDPROC   = 5'd22;
    localparam logic [KIND_W-1:0] K_ENDFUNC   = 5'd23;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_UNEXPECTED   = 3'd1,
        ST_MISMATCH     = 3'd2,
        ST_UNTERMINATED = 3'd3,
        ST_TOO_DEEP     = 3'd4,
        ST_HALTED       = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2
    } cell_op_t;

    typedef struct packed {
        logic [KIND_W-1:0] opener_kind;
        logic [KIND_W-1:0] expect_kind;
        logic [LINE_W-1:0] line;
    } entry_t;

    typedef struct packed {
        cell_op_t op;
        logic     replace;
        entry_t   new_entry;
    } stack_ctl_t;

    typedef struct packed {
        logic              linked;
        logic [LINE_W-1:0] opener_line;
        status_t           status;
        logic [LINE_W-1:0] error_line;
        logic [KIND_W-1:0] reported_kind;
        logic              scan_done;
    } res_t;

    typedef struct packed {
        logic [KIND_W-1:0] pushes;
        logic [KIND_W-1:0] expect1;
        logic [KIND_W-1:0] expect2;
        logic              shortable;
        logic              bodiless;
    } rule_t;

    function automatic rule_t rule_lookup(input logic [KIND_W-1:0] kind);
        rule_t r;
        r = '{pushes: K_NONE, expect1: K_NONE, expect2: K_NONE, shortable: 1'b0,
              bodiless: 1'b0};
        case (kind)
            K_FOR:       begin r.pushes = K_ENDFOR;   r.shortable = 1'b1; end
            K_IF:        begin r.pushes = K_ELIF;     r.shortable = 1'b1; end
            K_ELIF:      begin r.pushes = K_ELIF;     r.expect1 = K_ELIF; end
            K_ELSE:      begin r.pushes = K_ENDIF;    r.expect1 = K_ELIF; end
            K_WHILE:     begin r.pushes = K_ENDWHILE; r.shortable = 1'b1; end
            K_REPEAT:    begin r.pushes = K_UNTIL;    r.shortable = 1'b1; end
            K_LOOP:      r.pushes = K_ENDLOOP;
            K_CASE:      r.pushes = K_WHEN;
            K_WHEN:      begin r.pushes = K_WHEN;     r.expect1 = K_WHEN; end
            K_OTHERWISE: begin r.pushes = K_ENDCASE;  r.expect1 = K_WHEN; end
            K_TRAP:      begin r.pushes = K_HANDLER;  r.bodiless = 1'b1; end
            K_HANDLER:   begin r.pushes = K_ENDTRAP;  r.expect1 = K_HANDLER; end
            K_PROC:      begin r.pushes = K_ENDPROC;  r.bodiless = 1'b1; end
            K_FUNC:      begin r.pushes = K_ENDFUNC;  r.bodiless = 1'b1; end
            K_ENDFOR:    r.expect1 = K_ENDFOR;
            K_ENDIF:     begin r.expect1 = K_ENDIF;   r.expect2 = K_ELIF; end
            K_ENDWHILE:  r.expect1 = K_ENDWHILE;
            K_UNTIL:     r.expect1 = K_UNTIL;
            K_ENDLOOP:   r.expect1 = K_ENDLOOP;
            K_ENDCASE:   begin r.expect1 = K_ENDCASE; r.expect2 = K_WHEN; end
            K_ENDTRAP:   begin r.expect1 = K_ENDTRAP; r.expect2 = K_HANDLER; end
            K_ENDPROC:   r.expect1 = K_ENDPROC;
            K_ENDFUNC:   r.expect1 = K_ENDFUNC;
            default:     r.pushes = K_NONE;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/bknc_cell.sv =====
// One cell of the nesting stack: holds a single entry.
// Loads from the cell above on a push, from the cell below on a pop. Uses bknc_pkg.
`default_nettype none

module bknc_cell (
    input  wire logic              clk,
    input  wire bknc_pkg::cell_op_t op,
    input  wire bknc_pkg::entry_t  above,
    input  wire bknc_pkg::entry_t  below,
    output bknc_pkg::entry_t       entry
);
    import bknc_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        case (op)
            OP_PUSH: entry_next = above;
            OP_POP:  entry_next = below;
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// ===== src/bknc_ctrl.sv =====
// Rule decode, top-of-stack compare, stack count and halt flag of the nesting checker.
// Drives the cell chain and forms one result per request. Uses bknc_pkg.
`default_nettype none

module bknc_ctrl #(
    parameter int STACK_DEPTH = bknc_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [bknc_pkg::KIND_W-1:0]   kind,
    input  wire logic [bknc_pkg::LINE_W-1:0]   line,
    input  wire logic                          inline_body,
    input  wire logic                          no_body,
    input  wire logic                          last,
    input  wire bknc_pkg::entry_t              top_entry,
    input  wire bknc_pkg::entry_t              second_entry,
    output bknc_pkg::stack_ctl_t               ctl,
    output bknc_pkg::res_t                     res
);
    import bknc_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          halted_reg;
    logic          halted_next;

    rule_t         rule;
    logic          pop;
    logic          push;
    logic          skip;
    logic [CW-1:0] count_after_pop;
    logic [CW-1:0] count_final;
    entry_t        new_entry;
    entry_t        new_top;
    status_t       status;
    logic [LINE_W-1:0] eline;
    logic [KIND_W-1:0] rkind;
    logic          linked;
    logic [LINE_W-1:0] opl;

    always_comb
    begin
        rule = rule_lookup(kind);
        pop = 1'b0;
        push = 1'b0;
        linked = 1'b0;
        opl = '0;
        status = ST_OK;
        eline = '0;
        rkind = '0;
        skip = (rule.shortable && inline_body) || (rule.bodiless && no_body);
        new_entry = '{opener_kind: kind, expect_kind: rule.pushes, line: line};

        if (halted_reg)
        begin
            status = ST_HALTED;
        end
        else if (rule.expect1 != K_NONE)
        begin
            if (count_reg == '0)
            begin
                status = ST_UNEXPECTED;
                eline = line;
            end
            else if (top_entry.expect_kind != rule.expect1 &&
                     top_entry.expect_kind != rule.expect2)
            begin
                status = ST_MISMATCH;
                eline = line;
                rkind = top_entry.expect_kind;
            end
            else
            begin
                pop = 1'b1;
                linked = 1'b1;
                opl = top_entry.line;
            end
        end

        count_after_pop = count_reg - {{(CW-1){1'b0}}, pop};

        if (!halted_reg && status == ST_OK && rule.pushes != K_NONE && !skip)
        begin
            if (count_after_pop == CW'(STACK_DEPTH))
            begin
                status = ST_TOO_DEEP;
                eline = line;
            end
            else
            begin
                push = 1'b1;
            end
        end

        count_final = count_after_pop + {{(CW-1){1'b0}}, push};

        if (push)
        begin
            new_top = new_entry;
        end
        else if (pop)
        begin
            new_top = second_entry;
        end
        else
        begin
            new_top = top_entry;
        end

        if (!halted_reg && status == ST_OK && last && count_final != '0)
        begin
            status = ST_UNTERMINATED;
            eline = new_top.line;
            rkind = new_top.opener_kind;
        end

        halted_next = halted_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (last)
            begin
                halted_next = 1'b0;
                count_next = '0;
            end
            else
            begin
                halted_next = halted_reg || (status != ST_OK);
                count_next = count_final;
            end
        end

        ctl.new_entry = new_entry;
        ctl.replace = push && pop;
        if (!accept)
        begin
            ctl.op = OP_HOLD;
        end
        else if (push)
        begin
            ctl.op = OP_PUSH;
        end
        else if (pop)
        begin
            ctl.op = OP_POP;
        end
        else
        begin
            ctl.op = OP_HOLD;
        end

        res.linked = linked;
        res.opener_line = opl;
        res.status = status;
        res.error_line = eline;
        res.reported_kind = rkind;
        res.scan_done = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            halted_reg <= halted_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("Stack count exceeds the stack depth.");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> count_reg == '0 && !halted_reg)
        else $error("Final request did not clear the checker.");

    a_halt_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> ctl.op == OP_HOLD)
        else $error("Stack moved while halted.");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> ctl.op != OP_POP && !ctl.replace)
        else $error("Pop requested on an empty stack.");

endmodule

`default_nettype wire

// ===== src/bknc_out_skid.sv =====
// Output register with a skid stage for the nesting checker results.
// Lets one further request enter while a result is stalled. Uses bknc_pkg.
`default_nettype none

module bknc_out_skid (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire bknc_pkg::res_t res_in,
    input  wire logic           out_stall,
    output logic                out_valid,
    output bknc_pkg::res_t      res_out,
    output logic                full
);
    import bknc_pkg::*;

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_res_reg;
    res_t skid_res_reg;
    logic out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= skid_valid_reg || load;
            skid_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_res_reg <= skid_valid_reg ? skid_res_reg : res_in;
        end
        if (!out_free && load)
        begin
            skid_res_reg <= res_in;
        end
    end

    assign out_valid = out_valid_reg;
    assign res_out = out_res_reg;
    assign full = skid_valid_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid stage holds a result while the output is empty.");

    a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !load)
        else $error("Request taken while the skid stage is full.");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !out_stall |=> !skid_valid_reg && out_valid_reg)
        else $error("Skid stage failed to drain into the output register.");

endmodule

`default_nettype wire

// ===== src/block_keyword_nesting_checker_unit.sv =====
// Block keyword nesting checker: one statement per request, one result per request.
// Results are registered in the output register, going via the skid stage while stalled.
// Throughput: one request per cycle unless in_stall; the cell chain shifts on push or pop.
// A stalled output holds one result and one more in a skid stage; in_stall rises then.
// Reset clears the stack count, halt flag and result valids; stack cells need no clearing.
// Depends on bknc_pkg, bknc_cell, bknc_ctrl and bknc_out_skid.
`default_nettype none

module block_keyword_nesting_checker_unit #(
    parameter int STACK_DEPTH = bknc_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [bknc_pkg::KIND_W-1:0]     statement_kind,
    input  wire logic [bknc_pkg::LINE_W-1:0]     line_number,
    input  wire logic                            inline_body,
    input  wire logic                            no_body,
    input  wire logic                            last,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 linked,
    output logic [bknc_pkg::LINE_W-1:0]          opener_line,
    output logic [bknc_pkg::STATUS_W-1:0]        status,
    output logic [bknc_pkg::LINE_W-1:0]          error_line,
    output logic [bknc_pkg::KIND_W-1:0]          reported_kind,
    output logic                                 scan_done
);
    import bknc_pkg::*;

    logic       accept;
    logic       skid_full;
    stack_ctl_t ctl;
    res_t       res;
    res_t       res_q;
    entry_t     cells [STACK_DEPTH];

    assign in_stall = skid_full;
    assign accept = in_valid && !skid_full;

    bknc_ctrl #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .kind(statement_kind),
        .line(line_number),
        .inline_body(inline_body),
        .no_body(no_body),
        .last(last),
        .top_entry(cells[0]),
        .second_entry(cells[1]),
        .ctl(ctl),
        .res(res)
    );

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        cell_op_t cell_op;
        entry_t   above;
        entry_t   below;

        if (i == 0)
        begin : g_head
            assign cell_op = ctl.op;
            assign above = ctl.new_entry;
        end
        else
        begin : g_body
            assign cell_op = ctl.replace ? OP_HOLD : ctl.op;
            assign above = cells[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_tail
            assign below = cells[i];
        end
        else
        begin : g_mid
            assign below = cells[i+1];
        end

        bknc_cell u_cell (
            .clk(clk),
            .op(cell_op),
            .above(above),
            .below(below),
            .entry(cells[i])
        );
    end

    bknc_out_skid u_out (
        .clk(clk),
        .rst_n(rst_n),
        .load(accept),
        .res_in(res),
        .out_stall(out_stall),
        .out_valid(out_valid),
        .res_out(res_q),
        .full(skid_full)
    );

    assign linked = res_q.linked;
    assign opener_line = res_q.opener_line;
    assign status = res_q.status;
    assign error_line = res_q.error_line;
    assign reported_kind = res_q.reported_kind;
    assign scan_done = res_q.scan_done;

endmodule

`default_nettype wire
